// ===== rtl/video_transition_compositor_macros.svh =====
// Assertion macros for the video transition compositor.
// Used by the top level; expects clk and rst in scope.
`ifndef VIDEO_TRANSITION_COMPOSITOR_MACROS_SVH
`define VIDEO_TRANSITION_COMPOSITOR_MACROS_SVH

// same-cycle implication
`define VTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vtc assertion failed");

// next-cycle implication
`define VTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vtc assertion failed");

`endif

// ===== rtl/vtc_pkg.sv =====
// Types and constants of the video transition compositor.
// No dependencies.
package vtc_pkg;

  localparam int RANK_W = 13;

  typedef struct packed {
    logic        mode;
    logic [12:0] block_index;
    logic [12:0] block_rank;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] outgoing_pixel;
    logic [31:0] incoming_pixel;
  } in_t;

  typedef struct packed {
    logic [31:0] composed_pixel;
    logic        took_incoming;
  } out_t;

  localparam logic [1:0] TR_CUT      = 2'd0;
  localparam logic [1:0] TR_FADE     = 2'd1;
  localparam logic [1:0] TR_DISSOLVE = 2'd2;

  localparam logic [1:0] CRV_LINEAR = 2'd0;
  localparam logic [1:0] CRV_IN     = 2'd1;
  localparam logic [1:0] CRV_OUT    = 2'd2;
  localparam logic [1:0] CRV_SMOOTH = 2'd3;

  localparam logic [2:0] REG_TYPE   = 3'd0;
  localparam logic [2:0] REG_CURVE  = 3'd1;
  localparam logic [2:0] REG_PROG   = 3'd2;
  localparam logic [2:0] REG_BSIZE  = 3'd3;
  localparam logic [2:0] REG_FWIDTH = 3'd4;
  localparam logic [2:0] REG_BTOTAL = 3'd5;

  localparam logic        MODE_LOAD = 1'b0;
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [17:0] SS_K      = 18'd196608;
  localparam int          RECIP_SH  = 19;
  localparam int          DIV_STEPS = 20;
  localparam logic [4:0]  SETTLE_LAST = 5'd21;

endpackage

// ===== rtl/vtc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vtc_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/video_transition_compositor.sv =====
// Video transition compositor: hard cut, crossfade or macroblock dissolve.
// Depends on vtc_pkg, vtc_ram and video_transition_compositor_macros.svh.
// Registers d1-d4, res; one request per cycle unless setup or a result stall holds it.
// A stalled result freezes every stage and stalls new requests until it leaves.
// Reset (synchronous) and every register write start a setup of the
// eased progress, threshold and block divisors (bit-serial dividers); req_stall is high.
module video_transition_compositor #(
  parameter int MAX_BLOCKS = 8192
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  vtc_pkg::in_t  req,
  output logic          res_valid,
  input  logic          res_stall,
  output vtc_pkg::out_t res,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import vtc_pkg::*;
  `include "video_transition_compositor_macros.svh"

  localparam int AW = $clog2(MAX_BLOCKS);

  // configuration registers
  logic [1:0]  tr_type;
  logic [1:0]  curve;
  logic [16:0] prog;
  logic [6:0]  bsize;
  logic [12:0] fwidth;
  logic [13:0] btotal;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tr_type <= TR_CUT;
      curve   <= CRV_LINEAR;
      prog    <= '0;
      bsize   <= 7'd16;
      fwidth  <= 13'd1920;
      btotal  <= 14'd8160;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_TYPE:   tr_type <= pwdata[1:0];
        REG_CURVE:  curve   <= pwdata[1:0];
        REG_PROG:   prog    <= pwdata[16:0];
        REG_BSIZE:  bsize   <= pwdata[6:0];
        REG_FWIDTH: fwidth  <= pwdata[12:0];
        REG_BTOTAL: btotal  <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_TYPE:   prdata = {30'd0, tr_type};
      REG_CURVE:  prdata = {30'd0, curve};
      REG_PROG:   prdata = {15'd0, prog};
      REG_BSIZE:  prdata = {25'd0, bsize};
      REG_FWIDTH: prdata = {19'd0, fwidth};
      REG_BTOTAL: prdata = {18'd0, btotal};
      default:    prdata = '0;
    endcase
  end

  // setup sequencer: easing, threshold and two restoring dividers
  logic        busy;
  logic [4:0]  cnt;
  logic [16:0] p_clamp;
  logic [6:0]  bs_eff;
  logic [16:0] sq_in;
  logic [17:0] ss_k;
  logic [32:0] sqr;
  logic [34:0] ph;
  logic [33:0] pl;
  logic [51:0] ss_sum;
  logic [33:0] sq_rnd;
  logic [16:0] ease;
  logic [30:0] tprod;
  logic [15:0] thr;
  logic [19:0] qa, qb;
  logic [7:0]  ra, rb;
  logic [7:0]  ra_sh, rb_sh;
  logic [17:0] recip;
  logic [13:0] cols;

  assign p_clamp = (prog > ONE_Q16) ? ONE_Q16 : prog;
  assign bs_eff  = (bsize < 7'd4) ? 7'd4 : bsize;
  assign sq_in   = (curve == CRV_OUT) ? ONE_Q16 - p_clamp : p_clamp;
  assign ss_k    = SS_K - {p_clamp, 1'b0};
  assign ss_sum  = {1'b0, ph, 16'd0} + {18'd0, pl} + 52'h0_0000_8000_0000;
  assign sq_rnd  = {1'b0, sqr} + 34'd32768;
  assign ra_sh   = {ra[6:0], qa[DIV_STEPS-1]};
  assign rb_sh   = {rb[6:0], qb[DIV_STEPS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (cfg_wr) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == SETTLE_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (cnt == 5'd0) begin
        sqr <= 33'(sq_in * sq_in);
        qa  <= 20'(1) << RECIP_SH;
        qb  <= {6'd0, 14'({1'b0, fwidth} + {7'd0, bs_eff} - 14'd1)};
        ra  <= '0;
        rb  <= '0;
      end else if (cnt <= 5'(DIV_STEPS)) begin
        // one quotient bit per cycle
        if (ra_sh >= {1'b0, bs_eff}) begin
          ra <= ra_sh - {1'b0, bs_eff};
          qa <= {qa[DIV_STEPS-2:0], 1'b1};
        end else begin
          ra <= ra_sh;
          qa <= {qa[DIV_STEPS-2:0], 1'b0};
        end
        if (rb_sh >= {1'b0, bs_eff}) begin
          rb <= rb_sh - {1'b0, bs_eff};
          qb <= {qb[DIV_STEPS-2:0], 1'b1};
        end else begin
          rb <= rb_sh;
          qb <= {qb[DIV_STEPS-2:0], 1'b0};
        end
      end
      if (cnt == 5'd1) begin
        ph <= 35'(sqr[32:16] * ss_k);
      end
      if (cnt == 5'd2) begin
        pl <= 34'(sqr[15:0] * ss_k);
      end
      if (cnt == 5'd3) begin
        case (curve)
          CRV_IN:     ease <= sq_rnd[32:16];
          CRV_OUT:    ease <= ONE_Q16 - sq_rnd[32:16];
          CRV_SMOOTH: ease <= ss_sum[48:32];
          default:    ease <= p_clamp;
        endcase
      end
      if (cnt == 5'd4) begin
        tprod <= 31'(ease * btotal);
      end
      if (cnt == 5'd5) begin
        thr <= 16'((32'(tprod) + 32'd32768) >> 16);
      end
      if (cnt == SETTLE_LAST) begin
        recip <= 18'(qa + 20'd1);
        cols  <= qb[13:0];
      end
    end
  end

  // pixel pipeline
  logic        adv;
  logic        v1, v2, v3, v4;
  in_t         d1, d2, d3, d4;
  logic [9:0]  bx2, by2, bx3;
  logic [24:0] po2 [4];
  logic [24:0] pi2 [4];
  logic [31:0] blend3, blend4;
  logic [23:0] row3;
  logic        inside3;
  logic [29:0] qx1, qy1;
  logic [31:0] blend_c;
  logic [25:0] csum [4];
  logic [23:0] blk3;
  logic [23:0] widx3;
  logic        ok3, ok4;
  logic        ram_we;
  logic [RANK_W-1:0] rank4;
  out_t        res_next;

  assign adv       = !res_valid || !res_stall;
  assign req_stall = busy || !adv;
  assign qx1       = 30'(d1.pixel_x * recip);
  assign qy1       = 30'(d1.pixel_y * recip);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      csum[c] = 26'(po2[c]) + 26'(pi2[c]) + 26'd32768;
      blend_c[8*c +: 8] = csum[c][23:16];
    end
  end

  assign blk3   = row3 + {14'd0, bx3};
  assign ok3    = inside3 && (blk3 < {10'd0, btotal}) && (32'(blk3) < 32'(MAX_BLOCKS));
  assign widx3  = {11'd0, d3.block_index};
  assign ram_we = adv && v3 && (d3.mode == MODE_LOAD)
                  && (32'(d3.block_index) < 32'(MAX_BLOCKS));

  vtc_ram #(
    .WIDTH (RANK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_rank_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx3[AW-1:0]),
    .wdata (d3.block_rank),
    .re    (adv),
    .raddr (blk3[AW-1:0]),
    .rdata (rank4)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= req_valid && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1 <= req;
      d2 <= d1;
      bx2 <= qx1[RECIP_SH+9:RECIP_SH];
      by2 <= qy1[RECIP_SH+9:RECIP_SH];
      for (int c = 0; c < 4; c++) begin
        po2[c] <= 25'(d1.outgoing_pixel[8*c +: 8] * (ONE_Q16 - ease));
        pi2[c] <= 25'(d1.incoming_pixel[8*c +: 8] * ease);
      end
      d3 <= d2;
      bx3 <= bx2;
      row3 <= 24'(by2 * cols);
      inside3 <= {1'b0, d2.pixel_x} < fwidth;
      blend3 <= blend_c;
      d4 <= d3;
      ok4 <= ok3;
      blend4 <= blend3;
    end
  end

  always_comb begin
    res_next.composed_pixel = d4.outgoing_pixel;
    res_next.took_incoming  = 1'b0;
    case (tr_type)
      TR_FADE: begin
        res_next.composed_pixel = blend4;
        res_next.took_incoming  = (ease == ONE_Q16);
      end
      TR_DISSOLVE: begin
        if (ok4 && ({3'd0, rank4} < thr)) begin
          res_next.composed_pixel = d4.incoming_pixel;
          res_next.took_incoming  = 1'b1;
        end
      end
      default: begin
        if (p_clamp != '0) begin
          res_next.composed_pixel = d4.incoming_pixel;
          res_next.took_incoming  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= v4 && (d4.mode != MODE_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  `VTC_ASSERT_NOW(a_setup_stalls, busy, req_stall)
  `VTC_ASSERT_NEXT(a_load_no_result, adv && v4 && (d4.mode == MODE_LOAD), !res_valid)
  `VTC_ASSERT_NEXT(a_stall_holds_pipe, !adv, v1 == $past(v1) && v4 == $past(v4))
endmodule
